FILE: rtl/bpd_pkg.sv
`timescale 1ns / 1ps
package bpd_pkg;

    localparam int ADC_WIDTH           = 12;
    localparam int SAMPLES_PER_PHASE_N = 2;
    localparam int CAL_COUNT_WIDTH_DEF = 16;

    localparam int MODE_WIDTH = 2;
    localparam int SUM_WIDTH  = 15;
    localparam int DIFF_WIDTH = ADC_WIDTH + 1;
    // magnitude of the Q.4 mean
    localparam int Q_WIDTH    = ADC_WIDTH + 4;
    localparam int BASE_WIDTH = Q_WIDTH + 1;
    // room for threshold +/- hysteresis before collapse
    localparam int BAND_WIDTH = BASE_WIDTH + 1;
    localparam int READING_MAX = (1 << ADC_WIDTH) - 1;
    localparam int SPAN_Q4     = READING_MAX * 16;

    // x / N == (x * RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^SUM_WIDTH and N <= 8
    localparam int RECIP_SHIFT = SUM_WIDTH + 3;
    localparam int RECIP_WIDTH = RECIP_SHIFT + 1;
    localparam int RECIP_MULT  =
        ((1 << RECIP_SHIFT) + SAMPLES_PER_PHASE_N - 1) / SAMPLES_PER_PHASE_N;

    localparam int DIV_CNT_WIDTH = $clog2(Q_WIDTH);

    localparam int MARGIN_WIDTH = 16;
    localparam int HYST_WIDTH   = 12;
    localparam int REQ_WIDTH    = 8;

    localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(6554);
    localparam logic [HYST_WIDTH-1:0]   HYST_RESET   = HYST_WIDTH'(20);
    localparam logic [REQ_WIDTH-1:0]    HITS_RESET   = REQ_WIDTH'(1);
    localparam logic [REQ_WIDTH-1:0]    CLEARS_RESET = REQ_WIDTH'(3);

    localparam int PADDR_WIDTH = 4;
    localparam int PDATA_WIDTH = 32;

    typedef enum logic [1:0] {
        REG_MARGIN,
        REG_HYST,
        REG_HITS,
        REG_CLEARS
    } reg_idx_t;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_CAL_START,
        MODE_CAL_SAMPLE,
        MODE_CAL_FINISH,
        MODE_DETECT
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_DIFF,
        S_APPLY,
        S_DIV_LOAD,
        S_DIV,
        S_MARGIN,
        S_THRESH,
        S_BOUNDS,
        S_DECIDE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [MARGIN_WIDTH-1:0] relative_margin;
        logic [HYST_WIDTH-1:0]   hysteresis;
        logic [REQ_WIDTH-1:0]    hits_required;
        logic [REQ_WIDTH-1:0]    clears_required;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic avg;
        logic diff;
        logic apply;
        logic div_load;
        logic div_step;
        logic margin;
        logic thresh;
        logic bounds;
        logic decide;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  count_gt1;
    } stat_t;

endpackage

FILE: rtl/bpd_if.sv
`timescale 1ns / 1ps
interface bpd_in_if;
    logic                             valid;
    logic                             ready;
    logic [bpd_pkg::MODE_WIDTH-1:0]   mode;
    logic [bpd_pkg::SUM_WIDTH-1:0]    on_sum;
    logic [bpd_pkg::SUM_WIDTH-1:0]    off_sum;

    modport source (output valid, output mode, output on_sum, output off_sum, input ready);
    modport sink   (input valid, input mode, input on_sum, input off_sum, output ready);
endinterface

interface bpd_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   detected;
    logic signed [bpd_pkg::DIFF_WIDTH-1:0]  difference;
    logic signed [bpd_pkg::BASE_WIDTH-1:0]  baseline_out;
    logic                                   calibration_ok;

    modport source (output valid, output detected, output difference, output baseline_out,
                    output calibration_ok, input ready);
    modport sink   (input valid, input detected, input difference, input baseline_out,
                    input calibration_ok, output ready);
endinterface

FILE: rtl/bpd_regs.sv
`timescale 1ns / 1ps
module bpd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpd_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [bpd_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [bpd_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output bpd_pkg::cfg_t                    cfg
);
    import bpd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MARGIN: cfg_next.relative_margin   = pwdata[MARGIN_WIDTH-1:0];
                REG_HYST:   cfg_next.hysteresis        = pwdata[HYST_WIDTH-1:0];
                REG_HITS:   cfg_next.hits_required     = pwdata[REQ_WIDTH-1:0];
                REG_CLEARS: cfg_next.clears_required   = pwdata[REQ_WIDTH-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MARGIN: prdata = PDATA_WIDTH'(cfg_reg.relative_margin);
            REG_HYST:   prdata = PDATA_WIDTH'(cfg_reg.hysteresis);
            REG_HITS:   prdata = PDATA_WIDTH'(cfg_reg.hits_required);
            REG_CLEARS: prdata = PDATA_WIDTH'(cfg_reg.clears_required);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relative_margin   <= MARGIN_RESET;
            cfg_reg.hysteresis        <= HYST_RESET;
            cfg_reg.hits_required     <= HITS_RESET;
            cfg_reg.clears_required   <= CLEARS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/bpd_ctrl.sv
`timescale 1ns / 1ps
module bpd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  bpd_pkg::stat_t stat,
    output bpd_pkg::cmd_t  cmd
);
    import bpd_pkg::*;

    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(Q_WIDTH - 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [DIV_CNT_WIDTH-1:0] div_cnt_reg;
    logic [DIV_CNT_WIDTH-1:0] div_cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     slot_free;

    // result slot can take a new result when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_AVG;
            end
            S_AVG:      state_next = S_DIFF;
            S_DIFF:
            begin
                case (stat.mode)
                    MODE_DETECT:     state_next = S_BOUNDS;
                    MODE_CAL_FINISH: state_next = stat.count_gt1 ? S_DIV_LOAD : S_APPLY;
                    default:         state_next = S_APPLY;
                endcase
            end
            S_APPLY:    state_next = S_OUT;
            S_DIV_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_MARGIN;
            end
            S_MARGIN:   state_next = S_THRESH;
            S_THRESH:   state_next = S_OUT;
            S_BOUNDS:   state_next = S_DECIDE;
            S_DECIDE:   state_next = S_OUT;
            S_OUT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        div_cnt_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_AVG:      cmd.avg      = 1'b1;
            S_DIFF:     cmd.diff     = 1'b1;
            S_APPLY:    cmd.apply    = 1'b1;
            S_DIV_LOAD: cmd.div_load = 1'b1;
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            S_MARGIN:   cmd.margin   = 1'b1;
            S_THRESH:   cmd.thresh   = 1'b1;
            S_BOUNDS:   cmd.bounds   = 1'b1;
            S_DECIDE:   cmd.decide   = 1'b1;
            S_OUT:      cmd.out_load = slot_free;
            default:    cmd          = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/bpd_dp.sv
`timescale 1ns / 1ps
module bpd_dp #(
    parameter int CAL_COUNT_WIDTH = bpd_pkg::CAL_COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bpd_pkg::cmd_t                         cmd,
    output bpd_pkg::stat_t                        stat,
    input  bpd_pkg::cfg_t                         cfg,
    input  logic [bpd_pkg::MODE_WIDTH-1:0]        mode,
    input  logic [bpd_pkg::SUM_WIDTH-1:0]         on_sum,
    input  logic [bpd_pkg::SUM_WIDTH-1:0]         off_sum,
    output logic                                  detected,
    output logic signed [bpd_pkg::DIFF_WIDTH-1:0] difference,
    output logic signed [bpd_pkg::BASE_WIDTH-1:0] baseline_out,
    output logic                                  calibration_ok
);
    import bpd_pkg::*;

    localparam int CSUM_WIDTH = DIFF_WIDTH + CAL_COUNT_WIDTH;
    localparam int NUM_WIDTH  = CSUM_WIDTH + 4;
    localparam int REM_WIDTH  = CAL_COUNT_WIDTH + 1;
    localparam int PROD_WIDTH = SUM_WIDTH + RECIP_WIDTH;
    localparam int MPROD_WIDTH = MARGIN_WIDTH + Q_WIDTH;

    localparam logic [CAL_COUNT_WIDTH-1:0] CAL_COUNT_MAX = '1;
    localparam logic [PROD_WIDTH-1:0]      RECIP_K       = PROD_WIDTH'(RECIP_MULT);
    localparam logic signed [SUM_WIDTH:0]  DIFF_LIM      = (SUM_WIDTH + 1)'(READING_MAX);
    localparam logic signed [BAND_WIDTH-1:0] SPAN_LIM    = BAND_WIDTH'(SPAN_Q4);
    localparam logic [REQ_WIDTH-1:0]       CNT_SAT       = '1;

    // captured request and intermediate payload
    mode_t                          mode_reg;
    logic [SUM_WIDTH-1:0]           on_reg;
    logic [SUM_WIDTH-1:0]           off_reg;
    logic [SUM_WIDTH-1:0]           on_avg_reg;
    logic [SUM_WIDTH-1:0]           off_avg_reg;
    logic signed [DIFF_WIDTH-1:0]   diff_reg;
    logic                           neg_reg;
    logic [REM_WIDTH-1:0]           rem_reg;
    logic [Q_WIDTH-1:0]             quot_reg;
    logic [Q_WIDTH-1:0]             margin_reg;
    logic signed [BAND_WIDTH-1:0]   exit_lo_reg;
    logic signed [BAND_WIDTH-1:0]   exit_hi_reg;
    logic                           det_out_reg;
    logic signed [DIFF_WIDTH-1:0]   diff_out_reg;
    logic signed [BASE_WIDTH-1:0]   base_out_reg;
    logic                           ok_out_reg;

    // block state
    logic signed [CSUM_WIDTH-1:0]   cal_sum_reg,   cal_sum_next;
    logic [CAL_COUNT_WIDTH-1:0]     cal_count_reg, cal_count_next;
    logic signed [BASE_WIDTH-1:0]   baseline_reg,  baseline_next;
    logic signed [BASE_WIDTH-1:0]   upper_reg,     upper_next;
    logic signed [BASE_WIDTH-1:0]   lower_reg,     lower_next;
    logic                           cal_ok_reg,    cal_ok_next;
    logic                           det_reg,       det_next;
    logic [REQ_WIDTH-1:0]           hit_reg,       hit_next;
    logic [REQ_WIDTH-1:0]           clr_reg,       clr_next;

    // combinational terms
    logic [PROD_WIDTH-1:0]          on_prod;
    logic [PROD_WIDTH-1:0]          off_prod;
    logic signed [SUM_WIDTH:0]      diff_raw;
    logic signed [SUM_WIDTH:0]      diff_clamp;
    logic [CSUM_WIDTH-1:0]          mag;
    logic [NUM_WIDTH-1:0]           num;
    logic [REM_WIDTH-1:0]           trial;
    logic [REM_WIDTH-1:0]           divisor;
    logic                           q_bit;
    logic [MPROD_WIDTH-1:0]         m_prod;
    logic signed [BASE_WIDTH-1:0]   q_signed;
    logic signed [BAND_WIDTH-1:0]   up_raw;
    logic signed [BAND_WIDTH-1:0]   lo_raw;
    logic signed [BAND_WIDTH-1:0]   up_ext;
    logic signed [BAND_WIDTH-1:0]   lo_ext;
    logic signed [BAND_WIDTH-1:0]   hyst_ext;
    logic signed [BAND_WIDTH-1:0]   x_lo;
    logic signed [BAND_WIDTH-1:0]   x_hi;
    logic signed [BAND_WIDTH-1:0]   d16;
    logic [REQ_WIDTH-1:0]           hit_inc;
    logic [REQ_WIDTH-1:0]           clr_inc;

    assign on_prod  = PROD_WIDTH'(on_reg) * RECIP_K;
    assign off_prod = PROD_WIDTH'(off_reg) * RECIP_K;

    assign diff_raw = $signed({1'b0, on_avg_reg}) - $signed({1'b0, off_avg_reg});

    always_comb
    begin
        if (diff_raw > DIFF_LIM)
            diff_clamp = DIFF_LIM;
        else if (diff_raw < -DIFF_LIM)
            diff_clamp = -DIFF_LIM;
        else
            diff_clamp = diff_raw;
    end

    // restoring divide of |sum|*16 by count; quotient is known to fit Q_WIDTH
    assign mag     = cal_sum_reg[CSUM_WIDTH-1] ? CSUM_WIDTH'(-cal_sum_reg)
                                               : CSUM_WIDTH'(cal_sum_reg);
    assign num     = {mag, 4'b0000};
    assign divisor = {1'b0, cal_count_reg};
    assign trial   = {rem_reg[REM_WIDTH-2:0], quot_reg[Q_WIDTH-1]};
    assign q_bit   = (trial >= divisor);

    assign m_prod   = MPROD_WIDTH'(cfg.relative_margin) * MPROD_WIDTH'(quot_reg);
    assign q_signed = $signed({1'b0, quot_reg});

    assign up_ext   = BAND_WIDTH'(upper_reg);
    assign lo_ext   = BAND_WIDTH'(lower_reg);
    assign up_raw   = BAND_WIDTH'(baseline_reg) + $signed({2'b00, margin_reg});
    assign lo_raw   = BAND_WIDTH'(baseline_reg) - $signed({2'b00, margin_reg});
    assign hyst_ext = $signed(BAND_WIDTH'({cfg.hysteresis, 4'b0000}));
    assign x_lo     = lo_ext + hyst_ext;
    assign x_hi     = up_ext - hyst_ext;
    assign d16      = BAND_WIDTH'($signed({diff_reg, 4'b0000}));

    assign hit_inc = (hit_reg == CNT_SAT) ? hit_reg : hit_reg + 1'b1;
    assign clr_inc = (clr_reg == CNT_SAT) ? clr_reg : clr_reg + 1'b1;

    always_comb
    begin
        cal_sum_next   = cal_sum_reg;
        cal_count_next = cal_count_reg;
        baseline_next  = baseline_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        cal_ok_next    = cal_ok_reg;
        det_next       = det_reg;
        hit_next       = hit_reg;
        clr_next       = clr_reg;

        if (cmd.apply)
        begin
            case (mode_reg)
                MODE_CAL_START:
                begin
                    cal_sum_next   = '0;
                    cal_count_next = '0;
                    det_next       = 1'b0;
                    hit_next       = '0;
                    clr_next       = '0;
                end
                MODE_CAL_SAMPLE:
                begin
                    if (cal_count_reg != CAL_COUNT_MAX)
                    begin
                        cal_sum_next   = cal_sum_reg + CSUM_WIDTH'(diff_reg);
                        cal_count_next = cal_count_reg + 1'b1;
                    end
                end
                MODE_CAL_FINISH:
                begin
                    // fewer than two samples
                    baseline_next = '0;
                    upper_next    = '0;
                    lower_next    = '0;
                    cal_ok_next   = 1'b0;
                end
                default:
                begin
                    cal_sum_next = cal_sum_reg;
                end
            endcase
        end

        if (cmd.margin)
        begin
            baseline_next = neg_reg ? -q_signed : q_signed;
            cal_ok_next   = 1'b1;
        end

        if (cmd.thresh)
        begin
            if (up_raw > SPAN_LIM)
                upper_next = BASE_WIDTH'(SPAN_LIM);
            else if (up_raw < -SPAN_LIM)
                upper_next = BASE_WIDTH'(-SPAN_LIM);
            else
                upper_next = BASE_WIDTH'(up_raw);

            if (lo_raw > SPAN_LIM)
                lower_next = BASE_WIDTH'(SPAN_LIM);
            else if (lo_raw < -SPAN_LIM)
                lower_next = BASE_WIDTH'(-SPAN_LIM);
            else
                lower_next = BASE_WIDTH'(lo_raw);
        end

        if (cmd.decide)
        begin
            if (!det_reg)
            begin
                if (d16 <= lo_ext || d16 >= up_ext)
                begin
                    if (hit_inc >= cfg.hits_required)
                    begin
                        det_next = 1'b1;
                        hit_next = '0;
                        clr_next = '0;
                    end
                    else
                    begin
                        hit_next = hit_inc;
                    end
                end
                else
                begin
                    hit_next = '0;
                end
            end
            else
            begin
                if (d16 > exit_lo_reg && d16 < exit_hi_reg)
                begin
                    if (clr_inc >= cfg.clears_required)
                    begin
                        det_next = 1'b0;
                        clr_next = '0;
                        hit_next = '0;
                    end
                    else
                    begin
                        clr_next = clr_inc;
                    end
                end
                else
                begin
                    clr_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg   <= '0;
            cal_count_reg <= '0;
            baseline_reg  <= '0;
            upper_reg     <= '0;
            lower_reg     <= '0;
            cal_ok_reg    <= 1'b0;
            det_reg       <= 1'b0;
            hit_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            cal_sum_reg   <= cal_sum_next;
            cal_count_reg <= cal_count_next;
            baseline_reg  <= baseline_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            cal_ok_reg    <= cal_ok_next;
            det_reg       <= det_next;
            hit_reg       <= hit_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(mode);
            on_reg   <= on_sum;
            off_reg  <= off_sum;
        end
        if (cmd.avg)
        begin
            on_avg_reg  <= on_prod[RECIP_SHIFT +: SUM_WIDTH];
            off_avg_reg <= off_prod[RECIP_SHIFT +: SUM_WIDTH];
        end
        if (cmd.diff)
            diff_reg <= DIFF_WIDTH'(diff_clamp);
        if (cmd.div_load)
        begin
            neg_reg  <= cal_sum_reg[CSUM_WIDTH-1];
            rem_reg  <= num[NUM_WIDTH-1 -: REM_WIDTH];
            quot_reg <= num[Q_WIDTH-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? (trial - divisor) : trial;
            quot_reg <= {quot_reg[Q_WIDTH-2:0], q_bit};
        end
        if (cmd.margin)
            margin_reg <= m_prod[MARGIN_WIDTH +: Q_WIDTH];
        if (cmd.bounds)
        begin
            // an empty or inverted clear band falls back to the enter band
            if (x_lo >= x_hi)
            begin
                exit_lo_reg <= lo_ext;
                exit_hi_reg <= up_ext;
            end
            else
            begin
                exit_lo_reg <= x_lo;
                exit_hi_reg <= x_hi;
            end
        end
        if (cmd.out_load)
        begin
            det_out_reg  <= det_reg;
            diff_out_reg <= diff_reg;
            base_out_reg <= baseline_reg;
            ok_out_reg   <= cal_ok_reg;
        end
    end

    assign stat.mode      = mode_reg;
    assign stat.count_gt1 = (cal_count_reg > CAL_COUNT_WIDTH'(1));

    assign detected       = det_out_reg;
    assign difference     = diff_out_reg;
    assign baseline_out   = base_out_reg;
    assign calibration_ok = ok_out_reg;

endmodule

FILE: rtl/band_presence_detector_top.sv
`timescale 1ns / 1ps
// Channel   Kind          Payload
// in_ch     valid/ready   mode, on_sum, off_sum
// out_ch    valid/ready   detected, difference, baseline_out, calibration_ok
// cfg       APB write/rd  relative_margin, hysteresis, hits_required,
//                         clears_required at 0x0, 0x4, 0x8, 0xC
//
// One request at a time; calibration start/sample/short finish pass average,
// difference, apply and output; detect has bounds and decide in place of apply,
// and a full finish has the bit-per-cycle mean divider (Q_WIDTH steps) and margin stage.
// A result waits in the output register while the next request is accepted;
// a stalled output holds the following result back in its last step.
// rst_n clears the control state, calibration state and detection to zero.
module band_presence_detector_top #(
    parameter int CAL_COUNT_WIDTH = bpd_pkg::CAL_COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bpd_in_if.sink                          in_ch,
    bpd_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpd_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [bpd_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [bpd_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                            pready
);
    import bpd_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    bpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpd_dp #(
        .CAL_COUNT_WIDTH (CAL_COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg),
        .mode           (in_ch.mode),
        .on_sum         (in_ch.on_sum),
        .off_sum        (in_ch.off_sum),
        .detected       (out_ch.detected),
        .difference     (out_ch.difference),
        .baseline_out   (out_ch.baseline_out),
        .calibration_ok (out_ch.calibration_ok)
    );

endmodule

FILE: rtl/bpd_checker.sv
`timescale 1ns / 1ps
module bpd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  detected,
    input logic signed [bpd_pkg::DIFF_WIDTH-1:0] difference,
    input logic signed [bpd_pkg::BASE_WIDTH-1:0] baseline_out,
    input logic                                  calibration_ok
);
    import bpd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(detected) && $stable(difference)
                                    && $stable(baseline_out) && $stable(calibration_ok))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous still in work");

    // without a good calibration the baseline is zero
    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibration_ok |-> baseline_out == '0)
        else $error("nonzero baseline without calibration");

endmodule

bind band_presence_detector_top bpd_checker u_bpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .detected       (out_ch.detected),
    .difference     (out_ch.difference),
    .baseline_out   (out_ch.baseline_out),
    .calibration_ok (out_ch.calibration_ok)
);

FILE: tb/bpd_presence_checker.sv
`timescale 1ns / 1ps
module bpd_presence_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    bpd_in_if                               in_mon,
    bpd_out_if                              out_mon,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [bpd_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [bpd_pkg::PDATA_WIDTH-1:0] pwdata,
    output int                              errors,
    output int                              pending
);
    import bpd_pkg::*;

    localparam int CAL_SUM_WIDTH = DIFF_WIDTH + CAL_COUNT_WIDTH_DEF;

    typedef struct packed {
        logic                         detected;
        logic signed [DIFF_WIDTH-1:0] difference;
        logic signed [BASE_WIDTH-1:0] baseline;
        logic                         cal_ok;
    } reading_t;

    reading_t expected_readings[$];

    cfg_t                            cfg;
    logic signed [CAL_SUM_WIDTH-1:0] cal_total;
    logic [CAL_COUNT_WIDTH_DEF-1:0]  cal_samples;
    logic signed [BASE_WIDTH-1:0]    base_q4;
    logic signed [BASE_WIDTH-1:0]    upper_q4;
    logic signed [BASE_WIDTH-1:0]    lower_q4;
    logic                            det;
    logic                            cal_good;
    logic [REQ_WIDTH-1:0]            hit_run;
    logic [REQ_WIDTH-1:0]            clear_run;

    function automatic longint limit_span(longint v, longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    // advances the detector state by one request and returns the reading it reports
    function automatic reading_t predict_reading(mode_t mode, logic [SUM_WIDTH-1:0] on_sum,
                                                 logic [SUM_WIDTH-1:0] off_sum);
        longint   d;
        longint   d16;
        longint   mag;
        longint   q;
        longint   b;
        longint   margin;
        longint   hyst;
        longint   exit_lo;
        longint   exit_hi;
        longint   lo;
        longint   hi;
        reading_t r;
        d = limit_span(longint'(on_sum) / SAMPLES_PER_PHASE_N
                       - longint'(off_sum) / SAMPLES_PER_PHASE_N, READING_MAX);
        case (mode)
            MODE_CAL_START:
            begin
                cal_total   = '0;
                cal_samples = '0;
                det         = 1'b0;
                hit_run     = '0;
                clear_run   = '0;
            end
            MODE_CAL_SAMPLE:
            begin
                // samples past a full count are dropped
                if (cal_samples != '1)
                begin
                    cal_total   = cal_total + CAL_SUM_WIDTH'(d);
                    cal_samples = cal_samples + 1'b1;
                end
            end
            MODE_CAL_FINISH:
            begin
                if (cal_samples > 1)
                begin
                    mag = longint'(cal_total);
                    if (mag < 0)
                    begin
                        mag = -mag;
                    end
                    // magnitude first, so the Q.4 mean truncates toward zero
                    q = (mag * 16) / longint'(cal_samples);
                    b = (cal_total < 0) ? -q : q;
                    margin   = (longint'(cfg.relative_margin) * q) >> 16;
                    base_q4  = BASE_WIDTH'(b);
                    upper_q4 = BASE_WIDTH'(limit_span(b + margin, SPAN_Q4));
                    lower_q4 = BASE_WIDTH'(limit_span(b - margin, SPAN_Q4));
                    cal_good = 1'b1;
                end
                else
                begin
                    base_q4  = '0;
                    upper_q4 = '0;
                    lower_q4 = '0;
                    cal_good = 1'b0;
                end
            end
            default:
            begin
                d16     = d * 16;
                hyst    = longint'(cfg.hysteresis) * 16;
                lo      = longint'(lower_q4);
                hi      = longint'(upper_q4);
                exit_lo = lo + hyst;
                exit_hi = hi - hyst;
                // empty clear band falls back to the enter band
                if (exit_lo >= exit_hi)
                begin
                    exit_lo = lo;
                    exit_hi = hi;
                end
                if (!det)
                begin
                    if (d16 <= lo || d16 >= hi)
                    begin
                        if (hit_run != '1)
                        begin
                            hit_run = hit_run + 1'b1;
                        end
                        if (hit_run >= cfg.hits_required)
                        begin
                            det       = 1'b1;
                            hit_run   = '0;
                            clear_run = '0;
                        end
                    end
                    else
                    begin
                        hit_run = '0;
                    end
                end
                else
                begin
                    if (d16 > exit_lo && d16 < exit_hi)
                    begin
                        if (clear_run != '1)
                        begin
                            clear_run = clear_run + 1'b1;
                        end
                        if (clear_run >= cfg.clears_required)
                        begin
                            det       = 1'b0;
                            clear_run = '0;
                            hit_run   = '0;
                        end
                    end
                    else
                    begin
                        clear_run = '0;
                    end
                end
            end
        endcase
        r.detected   = det;
        r.difference = DIFF_WIDTH'(d);
        r.baseline   = base_q4;
        r.cal_ok     = cal_good;
        return r;
    endfunction

    task automatic flag_mismatch(string field, longint want, longint seen);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cfg = '{relative_margin: MARGIN_RESET, hysteresis: HYST_RESET,
                    hits_required: HITS_RESET, clears_required: CLEARS_RESET};
            cal_total   = '0;
            cal_samples = '0;
            base_q4     = '0;
            upper_q4    = '0;
            lower_q4    = '0;
            det         = 1'b0;
            cal_good    = 1'b0;
            hit_run     = '0;
            clear_run   = '0;
            errors      = 0;
            expected_readings.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_WIDTH-1:2]))
                    REG_MARGIN: cfg.relative_margin   = pwdata[MARGIN_WIDTH-1:0];
                    REG_HYST:   cfg.hysteresis        = pwdata[HYST_WIDTH-1:0];
                    REG_HITS:   cfg.hits_required     = pwdata[REQ_WIDTH-1:0];
                    REG_CLEARS: cfg.clears_required   = pwdata[REQ_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result with no request pending, difference %0d",
                             $time, out_mon.difference);
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_mon.detected !== want.detected)
                    begin
                        flag_mismatch("detected", want.detected, out_mon.detected);
                    end
                    if (out_mon.difference !== want.difference)
                    begin
                        flag_mismatch("difference", want.difference, out_mon.difference);
                    end
                    if (out_mon.baseline_out !== want.baseline)
                    begin
                        flag_mismatch("baseline_out", want.baseline, out_mon.baseline_out);
                    end
                    if (out_mon.calibration_ok !== want.cal_ok)
                    begin
                        flag_mismatch("calibration_ok", want.cal_ok, out_mon.calibration_ok);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                expected_readings.push_back(predict_reading(mode_t'(in_mon.mode),
                                                            in_mon.on_sum, in_mon.off_sum));
            end
            pending <= expected_readings.size();
        end
    end

endmodule

FILE: tb/band_presence_detector_top_tb.sv
`timescale 1ns / 1ps
module band_presence_detector_top_tb;
    import bpd_pkg::*;

    localparam int SUM_MAX            = 32760;
    localparam int IDLE_LIMIT         = 2000;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int SETTLE_CYCLES      = 40;
    localparam int PHASE_ITEMS        = 185;
    localparam int FULL_SCALE_SAMPLES = 12;

    logic                   clk     = 1'b0;
    logic                   rst_n   = 1'b0;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr   = '0;
    logic [PDATA_WIDTH-1:0] pwdata  = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    logic rx_hold   = 1'b0;
    logic rx_steady = 1'b0;
    logic tx_steady = 1'b0;
    int   errors;
    int   pending;
    int   items_sent = 0;
    int   quiet = 0;

    bpd_in_if  in_ch ();
    bpd_out_if out_ch ();

    band_presence_detector_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpd_presence_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= IDLE_LIMIT)
            begin
                $display("band_presence_detector_top_tb: FAIL");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    initial
    begin : receiver
        int r;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                rx_hold <= 1'b0;
            end
            else if (rx_steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    out_ch.ready <= 1'b1;
                end
                else
                begin
                    out_ch.ready <= 1'b0;
                    stall = (r < 96) ? $urandom_range(1, 3) : $urandom_range(15, 70);
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(mode_t m, int on_v, int off_v);
        int r;
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.on_sum  <= SUM_WIDTH'(on_v);
        in_ch.off_sum <= SUM_WIDTH'(off_v);
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 60)
        begin
            gap = 0;
        end
        else if (r < 95)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 60);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random sums whose halves differ by about d; large d saturates
    task automatic send_reading(mode_t m, int d);
        int m2;
        int lo_v;
        int hi_v;
        m2   = ((d < 0) ? -d : d) * 2;
        lo_v = (m2 + 1 >= SUM_MAX) ? 0 : $urandom_range(0, SUM_MAX - m2 - 1);
        hi_v = lo_v + m2 + $urandom_range(0, 1);
        if (hi_v > SUM_MAX)
        begin
            hi_v = SUM_MAX;
        end
        if (d >= 0)
        begin
            send_item(m, hi_v, lo_v);
        end
        else
        begin
            send_item(m, lo_v, hi_v);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_WIDTH'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int unsigned margin, int unsigned hyst, int unsigned hits,
                              int unsigned clears);
        reg_write(REG_MARGIN, margin);
        reg_write(REG_HYST, hyst);
        reg_write(REG_HITS, hits);
        reg_write(REG_CLEARS, clears);
    endtask

    // calibrate around a level, then detect readings near and away from it
    task automatic run_session();
        int level;
        int mag;
        int n;
        int k;
        int r;
        int w;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            level = $urandom_range(0, 6) - 3;
        end
        else if (r < 85)
        begin
            level = $urandom_range(20, 600);
        end
        else
        begin
            level = $urandom_range(600, READING_MAX);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            level = -level;
        end
        mag = (level < 0) ? -level : level;
        send_item(MODE_CAL_START, $urandom_range(0, SUM_MAX), $urandom_range(0, SUM_MAX));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        repeat (n) send_reading(MODE_CAL_SAMPLE, level + $urandom_range(0, 4) - 2);
        send_item(MODE_CAL_FINISH, $urandom_range(0, SUM_MAX), $urandom_range(0, SUM_MAX));
        k = $urandom_range(6, 30);
        repeat (k)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                w = mag / 16 + 1;
            end
            else if (r < 90)
            begin
                w = mag / 3 + 8;
            end
            else
            begin
                w = 2 * READING_MAX + 4000;
            end
            send_reading(MODE_DETECT, level + $urandom_range(0, 2 * w) - w);
        end
    endtask

    initial
    begin : stimulus
        int target;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_CAL_START;
        in_ch.on_sum  = '0;
        in_ch.off_sum = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero band before any calibration: every reading is outside
        send_item(MODE_DETECT, 0, 0);
        send_item(MODE_DETECT, SUM_MAX, 0);
        send_item(MODE_DETECT, 0, SUM_MAX);
        send_item(MODE_DETECT, 3, 2);
        send_item(MODE_CAL_FINISH, 0, 0);
        send_item(MODE_CAL_START, 77, 5);
        send_item(MODE_CAL_SAMPLE, 90, 10);
        send_item(MODE_CAL_FINISH, 0, 0);
        // mean of -1 over three samples truncates toward zero
        send_item(MODE_CAL_START, 0, 0);
        send_item(MODE_CAL_SAMPLE, 0, 0);
        send_item(MODE_CAL_SAMPLE, 1, 1);
        send_item(MODE_CAL_SAMPLE, 0, 2);
        send_item(MODE_CAL_FINISH, 0, 0);
        // baseline 100 counts; default hysteresis inverts the clear band
        send_item(MODE_CAL_START, 0, 0);
        send_item(MODE_CAL_SAMPLE, 200, 0);
        send_item(MODE_CAL_SAMPLE, 201, 1);
        send_item(MODE_CAL_FINISH, 0, 0);
        send_item(MODE_DETECT, 200, 0);
        send_item(MODE_DETECT, 240, 0);
        send_item(MODE_DETECT, 200, 0);
        send_item(MODE_DETECT, 200, 0);
        send_item(MODE_DETECT, 200, 0);
        send_item(MODE_DETECT, 400, 0);
        send_item(MODE_CAL_START, 0, 0);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0: set_config(0, 0, 1, 1);
                1: set_config(65535, 4095, 255, 255);
                // zero required counts behave as one
                2: set_config(6554, 20, 0, 0);
                default: set_config($urandom_range(0, 65535),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                : $urandom_range(0, 40),
                                    $urandom_range(1, 5), $urandom_range(1, 5));
            endcase
            tx_steady = (p == 3 || p == 5);
            rx_steady <= (p == 5);
            // long output stall while requests keep coming
            if (p == 3)
            begin
                rx_hold <= 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(mode_t'($urandom_range(0, 3)), $urandom_range(0, SUM_MAX),
                              $urandom_range(0, SUM_MAX));
                end
                else
                begin
                    run_session();
                end
            end
        end

        // calibrate on full-scale readings, then add one of the opposite sign
        drain();
        set_config(65535, 0, 1, 2);
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_item(MODE_CAL_START, 0, 0);
        repeat (FULL_SCALE_SAMPLES)
        begin
            send_item(MODE_CAL_SAMPLE, $urandom_range(32000, SUM_MAX), $urandom_range(0, 700));
        end
        send_item(MODE_CAL_SAMPLE, 0, SUM_MAX);
        send_item(MODE_CAL_FINISH, 0, 0);
        send_item(MODE_DETECT, SUM_MAX, 0);
        send_item(MODE_DETECT, 0, 0);
        send_item(MODE_DETECT, 0, 0);
        send_item(MODE_DETECT, 0, SUM_MAX);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("band_presence_detector_top_tb: PASS");
        end
        else
        begin
            $display("band_presence_detector_top_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: band_presence_detector_top.f
rtl/bpd_pkg.sv
rtl/bpd_if.sv
rtl/bpd_regs.sv
rtl/bpd_ctrl.sv
rtl/bpd_dp.sv
rtl/band_presence_detector_top.sv
rtl/bpd_checker.sv
tb/bpd_presence_checker.sv
tb/band_presence_detector_top_tb.sv
